@@ rtl/ruci_pkg.sv @@
// ----------------------------------------------------------------------------
// ruci_pkg
// shared constants, face tables and saturation helpers for the ray / unit
// cube intersection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package ruci_pkg;

    localparam int OW       = 32;   // origin and point width
    localparam int KW       = 18;   // direction width
    localparam int TOLW     = 16;   // zero tolerance width
    localparam int NFACE    = 6;
    localparam int FACEW    = 3;
    localparam int DISTW    = 31;
    localparam int TEXW     = 18;
    localparam int FAR_BITS = 27;   // 100e6 < 2^27
    localparam int PW       = FAR_BITS + KW + 1;   // signed point before saturation

    localparam logic [63:0] FAR_INT = 64'd100000000;

    // configuration register indexes
    localparam logic [0:0] CFG_OBJECT_VISIBLE = 1'b0;
    localparam logic [0:0] CFG_ZERO_TOLERANCE = 1'b1;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // face codes
    localparam logic [FACEW-1:0] FACE_ZP = 3'd0;
    localparam logic [FACEW-1:0] FACE_ZN = 3'd1;
    localparam logic [FACEW-1:0] FACE_XN = 3'd2;
    localparam logic [FACEW-1:0] FACE_XP = 3'd3;
    localparam logic [FACEW-1:0] FACE_YN = 3'd4;
    localparam logic [FACEW-1:0] FACE_YP = 3'd5;

    typedef struct packed {
        logic signed [OW-1:0] ox;
        logic signed [OW-1:0] oy;
        logic signed [OW-1:0] oz;
        logic signed [KW-1:0] kx;
        logic signed [KW-1:0] ky;
        logic signed [KW-1:0] kz;
        logic [NFACE-1:0]     cand;
    } side_t;

    // axis normal to the face
    function automatic logic [1:0] face_axis(input logic [FACEW-1:0] f);
        logic [1:0] a;
        case (f)
            FACE_ZP, FACE_ZN: a = AXIS_Z;
            FACE_XN, FACE_XP: a = AXIS_X;
            FACE_YN, FACE_YP: a = AXIS_Y;
            default:          a = AXIS_X;
        endcase
        return a;
    endfunction

    // plane at +1 (else -1)
    function automatic logic face_plus(input logic [FACEW-1:0] f);
        logic p;
        case (f)
            FACE_ZP, FACE_XP, FACE_YP: p = 1'b1;
            default:                   p = 1'b0;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] face_uax(input logic [FACEW-1:0] f);
        logic [1:0] a;
        case (f)
            FACE_XN, FACE_XP: a = AXIS_Z;
            default:          a = AXIS_X;
        endcase
        return a;
    endfunction

    function automatic logic [1:0] face_vax(input logic [FACEW-1:0] f);
        logic [1:0] a;
        case (f)
            FACE_YN, FACE_YP: a = AXIS_Z;
            default:          a = AXIS_Y;
        endcase
        return a;
    endfunction

    function automatic logic signed [OW-1:0] sat_ow(input logic signed [PW-1:0] x);
        logic signed [OW-1:0] r;
        if (x > PW'(64'sh7FFFFFFF))
            r = 32'sh7FFFFFFF;
        else if (x < -PW'(64'sh80000000))
            r = 32'sh80000000;
        else
            r = x[OW-1:0];
        return r;
    endfunction

    function automatic logic signed [TEXW-1:0] sat_tex(input logic signed [PW-1:0] x);
        logic signed [TEXW-1:0] r;
        if (x > PW'(64'sd131071))
            r = 18'sh1FFFF;
        else if (x < -PW'(64'sd131072))
            r = 18'sh20000;
        else
            r = x[TEXW-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ruci_div_step.sv @@
// ----------------------------------------------------------------------------
// ruci_div_step
// one registered restoring division step, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module ruci_div_step #(
    parameter int DW = 48
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [DW-1:0]            w_in,     // dividend bits on top, quotient below
    input  wire logic [ruci_pkg::KW-1:0]  rem_in,
    input  wire logic [ruci_pkg::KW-1:0]  den_in,
    output logic      [DW-1:0]            w_out,
    output logic      [ruci_pkg::KW-1:0]  rem_out,
    output logic      [ruci_pkg::KW-1:0]  den_out
);

    logic [ruci_pkg::KW:0]   trial;
    logic                    ge;
    logic [ruci_pkg::KW-1:0] rem_next;
    logic [DW-1:0]           w_next;
    logic [DW-1:0]           w_reg;
    logic [ruci_pkg::KW-1:0] rem_reg;
    logic [ruci_pkg::KW-1:0] den_reg;

    assign trial    = {rem_in, w_in[DW-1]};
    assign ge       = trial >= {1'b0, den_in};
    assign rem_next = ge ? ruci_pkg::KW'(trial - {1'b0, den_in}) : trial[ruci_pkg::KW-1:0];
    assign w_next   = {w_in[DW-2:0], ge};

    always_ff @(posedge clk) begin
        if (en)
        begin
            w_reg   <= w_next;
            rem_reg <= rem_next;
            den_reg <= den_in;
        end
    end

    assign w_out   = w_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;

endmodule

`default_nettype wire

@@ rtl/ruci_mulfix.sv @@
// ----------------------------------------------------------------------------
// ruci_mulfix
// origin + (t * k >> frac) with truncated magnitude, three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module ruci_mulfix #(
    parameter int FRAC_BITS = 16,
    parameter int TW        = 43
) (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [TW-1:0]                   t,
    input  wire logic signed [ruci_pkg::KW-1:0]  k,
    input  wire logic signed [ruci_pkg::OW-1:0]  o,
    output logic signed [ruci_pkg::PW-1:0]       p
);

    localparam int LW = TW / 2;
    localparam int HW = TW - LW;
    localparam int KW = ruci_pkg::KW;
    localparam int MW = TW + KW - FRAC_BITS;
    localparam int PW = ruci_pkg::PW;

    logic [KW-1:0]               kmag;
    logic [LW+KW-1:0]            pl_reg;
    logic [HW+KW-1:0]            ph_reg;
    logic                        neg1_reg;
    logic signed [ruci_pkg::OW-1:0] o1_reg;
    logic [TW+KW-1:0]            full;
    logic [MW-1:0]               mag_reg;
    logic                        neg2_reg;
    logic signed [ruci_pkg::OW-1:0] o2_reg;
    logic signed [PW-1:0]        smag;
    logic signed [PW-1:0]        p_reg;

    assign kmag = k[KW-1] ? KW'(-k) : k;
    assign full = {ph_reg, {LW{1'b0}}} + (TW+KW)'(pl_reg);
    assign smag = neg2_reg ? -$signed(PW'(mag_reg)) : $signed(PW'(mag_reg));

    always_ff @(posedge clk) begin
        if (en)
        begin
            // partial products
            pl_reg   <= t[LW-1:0] * kmag;
            ph_reg   <= t[TW-1:LW] * kmag;
            neg1_reg <= k[KW-1];
            o1_reg   <= o;
            // sum and scale
            mag_reg  <= MW'(full >> FRAC_BITS);
            neg2_reg <= neg1_reg;
            o2_reg   <= o1_reg;
            // sign and origin
            p_reg    <= PW'(o2_reg) + smag;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ rtl/ruci_select.sv @@
// ----------------------------------------------------------------------------
// ruci_select
// in-face bounds check and nearest-face pick over a registered tree
// ----------------------------------------------------------------------------
`default_nettype none

module ruci_select #(
    parameter int FRAC_BITS = 16,
    parameter int TW        = 43
) (
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic [ruci_pkg::NFACE-1:0]           ok,
    input  wire logic [TW-1:0]                        t [0:ruci_pkg::NFACE-1],
    input  wire logic signed [ruci_pkg::PW-1:0]       p [0:ruci_pkg::NFACE-1][0:2],
    output logic                                      sel_ok,
    output logic [ruci_pkg::FACEW-1:0]                sel_face,
    output logic [TW-1:0]                             sel_t,
    output logic signed [ruci_pkg::PW-1:0]            sel_p [0:2]
);

    localparam int PW = ruci_pkg::PW;
    localparam logic signed [PW-1:0] ONE = PW'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic                          ok;
        logic [ruci_pkg::FACEW-1:0]    face;
        logic [TW-1:0]                 t;
        logic signed [PW-1:0]          p0;
        logic signed [PW-1:0]          p1;
        logic signed [PW-1:0]          p2;
    } cand_t;

    function automatic cand_t pick(input cand_t a, input cand_t b);
        cand_t r;
        if (a.ok && (!b.ok || a.t <= b.t))
            r = a;
        else
            r = b;
        return r;
    endfunction

    cand_t c [0:ruci_pkg::NFACE-1];
    cand_t s1_reg [0:2];
    cand_t s2_reg [0:1];
    cand_t s3_reg;

    for (genvar f = 0; f < ruci_pkg::NFACE; f++) begin : g_face
        localparam logic [1:0] UA = ruci_pkg::face_uax(3'(f));
        localparam logic [1:0] VA = ruci_pkg::face_vax(3'(f));
        logic in_u;
        logic in_v;
        assign in_u = (p[f][UA] >= -ONE) && (p[f][UA] <= ONE);
        assign in_v = (p[f][VA] >= -ONE) && (p[f][VA] <= ONE);
        assign c[f] = '{ok: ok[f] && in_u && in_v, face: 3'(f), t: t[f],
                        p0: p[f][0], p1: p[f][1], p2: p[f][2]};
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            // lower face wins a tie at every level
            s1_reg[0] <= pick(c[0], c[1]);
            s1_reg[1] <= pick(c[2], c[3]);
            s1_reg[2] <= pick(c[4], c[5]);
            s2_reg[0] <= pick(s1_reg[0], s1_reg[1]);
            s2_reg[1] <= s1_reg[2];
            s3_reg    <= pick(s2_reg[0], s2_reg[1]);
        end
    end

    assign sel_ok   = s3_reg.ok;
    assign sel_face = s3_reg.face;
    assign sel_t    = s3_reg.t;
    assign sel_p[0] = s3_reg.p0;
    assign sel_p[1] = s3_reg.p1;
    assign sel_p[2] = s3_reg.p2;

endmodule

`default_nettype wire

@@ rtl/ray_unit_cube_intersection.sv @@
// ----------------------------------------------------------------------------
// ray_unit_cube_intersection
// nearest face hit of a ray against the cube spanning -1..+1 on every axis
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      origin x/y/z, direction x/y/z
//  m_axis    out  m_axis_tvalid/tready      hit (tuser), face, distance, u, v, point
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  one ray per cycle while m_axis does not stall
//  the pipeline is made of the restoring dividers, one quotient bit per stage
//  over a 32 + FRAC_BITS bit dividend, plus one entry, three multiply and
//  three select stages and the output register
//  a stall on m_axis freezes the whole pipeline; nothing is dropped or repeated
//  rst_n clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module ray_unit_cube_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // s_axis_tdata from bit 0: origin_x[32] origin_y[32] origin_z[32]
    //                          dir_x[18] dir_y[18] dir_z[18] pad[2]
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [151:0]  s_axis_tdata,
    // m_axis_tdata from bit 0: face[3] hit_distance[31] tex_u[18] tex_v[18]
    //                          point_x[32] point_y[32] point_z[32] pad[2]
    // m_axis_tuser: hit[1]
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [167:0]       m_axis_tdata,
    output logic               m_axis_tuser,
    // register write channel
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);

    localparam int OW    = ruci_pkg::OW;
    localparam int KW    = ruci_pkg::KW;
    localparam int PW    = ruci_pkg::PW;
    localparam int NFACE = ruci_pkg::NFACE;
    localparam int DW    = 32 + FRAC_BITS;                  // dividend width
    localparam int TW    = ruci_pkg::FAR_BITS + FRAC_BITS;  // distance width below far clip
    localparam int NST   = DW + 7;                          // stages before the output register

    localparam logic signed [33:0] ONE34 = 34'sd1 <<< FRAC_BITS;
    localparam logic [DW-1:0]      FAR   = DW'(ruci_pkg::FAR_INT) << FRAC_BITS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                      visible_reg;
    logic [ruci_pkg::TOLW-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            visible_reg <= 1'b1;
            tol_reg     <= 16'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ruci_pkg::CFG_OBJECT_VISIBLE: visible_reg <= cfg_data[0];
                ruci_pkg::CFG_ZERO_TOLERANCE: tol_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: everything moves when the output slot frees up
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;
    logic vld_reg [0:NST-1];

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                vld_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NST; i++)
                vld_reg[i] <= vld_reg[i-1];
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    // ------------------------------------------------------------------
    // entry stage: face numerators, divisors, candidate flags
    // ------------------------------------------------------------------
    logic signed [OW-1:0]   o_in [0:2];
    logic signed [KW-1:0]   k_in [0:2];
    logic [KW-1:0]          kmag_in [0:2];
    logic [2:0]             par_in;
    logic [DW-1:0]          num_next [0:NFACE-1];
    logic [NFACE-1:0]       cand_next;
    logic [DW-1:0]          num_reg [0:NFACE-1];
    logic [KW-1:0]          den_reg [0:2];
    ruci_pkg::side_t        side0_reg;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign o_in[a]    = s_axis_tdata[OW*a +: OW];
        assign k_in[a]    = s_axis_tdata[3*OW + KW*a +: KW];
        assign kmag_in[a] = k_in[a][KW-1] ? KW'(-k_in[a]) : k_in[a];
        // parallel axis: zero, or below the tolerance
        assign par_in[a]  = (k_in[a] == '0) || (kmag_in[a] < KW'(tol_reg));
    end

    for (genvar f = 0; f < NFACE; f++) begin : g_prep
        localparam logic [1:0] AX   = ruci_pkg::face_axis(3'(f));
        localparam logic       PLUS = ruci_pkg::face_plus(3'(f));
        logic signed [33:0] diff;
        logic [31:0]        dmag;
        logic               pos;
        assign diff = PLUS ? (34'(o_in[AX]) - ONE34) : (34'(o_in[AX]) + ONE34);
        assign dmag = diff[33] ? 32'(-diff) : diff[31:0];
        // distance sign: offset and direction point opposite ways
        assign pos  = (diff != '0) && (diff[33] ^ k_in[AX][KW-1]);
        assign num_next[f]  = {dmag, {FRAC_BITS{1'b0}}};
        assign cand_next[f] = visible_reg && !par_in[AX] && pos;
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            for (int f = 0; f < NFACE; f++)
                num_reg[f] <= num_next[f];
            for (int a = 0; a < 3; a++)
                den_reg[a] <= kmag_in[a];
            side0_reg <= '{ox: o_in[0], oy: o_in[1], oz: o_in[2],
                           kx: k_in[0], ky: k_in[1], kz: k_in[2], cand: cand_next};
        end
    end

    // ------------------------------------------------------------------
    // divider chain, one per face, ray data alongside
    // ------------------------------------------------------------------
    logic [DW-1:0]   dq [0:DW-1][0:NFACE-1];
    logic [KW-1:0]   dr [0:DW-1][0:NFACE-1];
    logic [KW-1:0]   dd [0:DW-1][0:NFACE-1];
    ruci_pkg::side_t sd_reg [0:DW-1];

    for (genvar s = 0; s < DW; s++) begin : g_div
        for (genvar f = 0; f < NFACE; f++) begin : g_f
            if (s == 0)
            begin : g_first
                ruci_div_step #(.DW(DW)) u_step (
                    .clk     (clk),
                    .en      (adv),
                    .w_in    (num_reg[f]),
                    .rem_in  ('0),
                    .den_in  (den_reg[ruci_pkg::face_axis(3'(f))]),
                    .w_out   (dq[s][f]),
                    .rem_out (dr[s][f]),
                    .den_out (dd[s][f])
                );
            end
            else
            begin : g_next
                ruci_div_step #(.DW(DW)) u_step (
                    .clk     (clk),
                    .en      (adv),
                    .w_in    (dq[s-1][f]),
                    .rem_in  (dr[s-1][f]),
                    .den_in  (dd[s-1][f]),
                    .w_out   (dq[s][f]),
                    .rem_out (dr[s][f]),
                    .den_out (dd[s][f])
                );
            end
        end
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            sd_reg[0] <= side0_reg;
            for (int s = 1; s < DW; s++)
                sd_reg[s] <= sd_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // distance check and hit point per face
    // ------------------------------------------------------------------
    ruci_pkg::side_t      side_end;
    logic signed [OW-1:0] o_end [0:2];
    logic signed [KW-1:0] k_end [0:2];
    logic [NFACE-1:0]     tok;
    logic [TW-1:0]        tq [0:NFACE-1];
    logic [NFACE-1:0]     okd_reg [0:2];
    logic [TW-1:0]        td_reg [0:2][0:NFACE-1];
    logic signed [PW-1:0] pm [0:NFACE-1][0:2];

    assign side_end = sd_reg[DW-1];
    assign o_end[0] = side_end.ox;
    assign o_end[1] = side_end.oy;
    assign o_end[2] = side_end.oz;
    assign k_end[0] = side_end.kx;
    assign k_end[1] = side_end.ky;
    assign k_end[2] = side_end.kz;

    for (genvar f = 0; f < NFACE; f++) begin : g_mul
        // 0 < t < far clip
        assign tok[f] = side_end.cand[f] && (dq[DW-1][f] != '0) && (dq[DW-1][f] < FAR);
        assign tq[f]  = dq[DW-1][f][TW-1:0];
        for (genvar j = 0; j < 3; j++) begin : g_c
            ruci_mulfix #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_mul (
                .clk (clk),
                .en  (adv),
                .t   (tq[f]),
                .k   (k_end[j]),
                .o   (o_end[j]),
                .p   (pm[f][j])
            );
        end
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            okd_reg[0] <= tok;
            okd_reg[1] <= okd_reg[0];
            okd_reg[2] <= okd_reg[1];
            for (int f = 0; f < NFACE; f++)
            begin
                td_reg[0][f] <= tq[f];
                td_reg[1][f] <= td_reg[0][f];
                td_reg[2][f] <= td_reg[1][f];
            end
        end
    end

    // ------------------------------------------------------------------
    // nearest face
    // ------------------------------------------------------------------
    logic                         sel_ok;
    logic [ruci_pkg::FACEW-1:0]   sel_face;
    logic [TW-1:0]                sel_t;
    logic signed [PW-1:0]         sel_p [0:2];

    ruci_select #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_select (
        .clk      (clk),
        .en       (adv),
        .ok       (okd_reg[2]),
        .t        (td_reg[2]),
        .p        (pm),
        .sel_ok   (sel_ok),
        .sel_face (sel_face),
        .sel_t    (sel_t),
        .sel_p    (sel_p)
    );

    // ------------------------------------------------------------------
    // output register: saturation, all zero on a miss
    // ------------------------------------------------------------------
    logic                           hit_reg;
    logic [ruci_pkg::FACEW-1:0]     face_reg;
    logic [ruci_pkg::DISTW-1:0]     dist_reg;
    logic signed [ruci_pkg::TEXW-1:0] u_reg;
    logic signed [ruci_pkg::TEXW-1:0] v_reg;
    logic signed [OW-1:0]           pt_reg [0:2];
    logic [ruci_pkg::DISTW-1:0]     dist_next;

    assign dist_next = (|sel_t[TW-1:ruci_pkg::DISTW]) ? '1 : sel_t[ruci_pkg::DISTW-1:0];

    always_ff @(posedge clk) begin
        if (adv)
        begin
            hit_reg  <= sel_ok;
            face_reg <= sel_ok ? sel_face : ruci_pkg::FACE_ZP;
            dist_reg <= sel_ok ? dist_next : '0;
            u_reg    <= sel_ok ? ruci_pkg::sat_tex(sel_p[ruci_pkg::face_uax(sel_face)]) : '0;
            v_reg    <= sel_ok ? ruci_pkg::sat_tex(sel_p[ruci_pkg::face_vax(sel_face)]) : '0;
            for (int j = 0; j < 3; j++)
                pt_reg[j] <= sel_ok ? ruci_pkg::sat_ow(sel_p[j]) : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = hit_reg;
    assign m_axis_tdata  = {2'b00, pt_reg[2], pt_reg[1], pt_reg[0],
                            v_reg, u_reg, dist_reg, face_reg};

`ifndef ASSERT_OFF
    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss with nonzero payload");

    // a hit names a real face
    a_hit_face: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (face_reg <= ruci_pkg::FACE_YP))
        else $error("hit with face code out of range");

    // a hit lies at a positive distance
    a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (dist_reg != '0))
        else $error("hit at zero distance");

    // a stalled output freezes the pipeline tail
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_reg[NST-1]))
        else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for ray_unit_cube_intersection: rays go in on s_axis,
// each accepted ray is traced against the unit cube by a bench-side model,
// and every m_axis transfer is checked field by field against the oldest
// expected hit record, across several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam longint ONE       = 64'sd65536;
    localparam longint FAR_CLIP  = 64'sd100000000 * 64'sd65536;
    localparam int     LATENCY   = 64;
    localparam int     PER_PHASE = 210;

    // hit record as the block reports it
    typedef struct {
        bit                   hit;
        logic [2:0]           face;
        logic [30:0]          hit_dist;
        logic signed [17:0]   u;
        logic signed [17:0]   v;
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic signed [31:0]   pz;
    } cube_hit_t;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [151:0]  s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [167:0]  m_axis_tdata;
    logic          m_axis_tuser;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [0:0]    cfg_index;
    logic [15:0]   cfg_data;

    // bench copy of the registers
    bit            vis_q;
    logic [15:0]   tol_q;

    logic [151:0]  ray_queue[$];
    cube_hit_t     hit_queue[$];
    int            mismatches;

    // idle control
    bit            send_gaps;
    bit            recv_gaps;
    int            send_wait;
    int            recv_wait;
    bit            hold_on;
    bit            s_took;
    bit            m_took;

    // face tables: normal axis, plane sign, u axis, v axis
    logic [1:0]    normal_ax[6];
    longint        plane_of[6];
    logic [1:0]    u_ax[6];
    logic [1:0]    v_ax[6];

    ray_unit_cube_intersection i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // ox oy oz kx ky kz pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // face hit_distance u v px py pz pad
        .m_axis_tuser  (m_axis_tuser),   // hit
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        normal_ax = '{ruci_pkg::AXIS_Z, ruci_pkg::AXIS_Z, ruci_pkg::AXIS_X,
                      ruci_pkg::AXIS_X, ruci_pkg::AXIS_Y, ruci_pkg::AXIS_Y};
        plane_of  = '{64'sd1, -64'sd1, -64'sd1, 64'sd1, -64'sd1, 64'sd1};
        u_ax      = '{ruci_pkg::AXIS_X, ruci_pkg::AXIS_X, ruci_pkg::AXIS_Z,
                      ruci_pkg::AXIS_Z, ruci_pkg::AXIS_X, ruci_pkg::AXIS_X};
        v_ax      = '{ruci_pkg::AXIS_Y, ruci_pkg::AXIS_Y, ruci_pkg::AXIS_Y,
                      ruci_pkg::AXIS_Y, ruci_pkg::AXIS_Z, ruci_pkg::AXIS_Z};
    end

    function automatic logic [151:0] pack_ray(longint ox, longint oy, longint oz,
                                              longint kx, longint ky, longint kz);
        return {2'b00, kz[17:0], ky[17:0], kx[17:0], oz[31:0], oy[31:0], ox[31:0]};
    endfunction

    // (t * k) >> 16 with the magnitude truncated, capped at 2^62
    function automatic longint scale_fix(longint t, longint k);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] r;
        ma = (t < 0) ? -t : t;
        mb = (k < 0) ? -k : k;
        r  = (ma * mb) >> 16;
        if (r > (64'd1 << 62))
            r = 64'd1 << 62;
        return ((t < 0) != (k < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // nearest qualifying face of the ray against the -1..+1 cube
    function automatic cube_hit_t trace_cube(logic [151:0] ray);
        cube_hit_t res;
        longint    o[3];
        longint    k[3];
        longint    t;
        longint    u;
        longint    v;
        longint    best_t;
        longint    best_u;
        longint    best_v;
        longint    p[3];
        longint    kabs;
        int        best_f;
        bit        found;
        res = '{default: '0};
        o[0] = longint'($signed(ray[31:0]));
        o[1] = longint'($signed(ray[63:32]));
        o[2] = longint'($signed(ray[95:64]));
        k[0] = longint'($signed(ray[113:96]));
        k[1] = longint'($signed(ray[131:114]));
        k[2] = longint'($signed(ray[149:132]));
        found  = 1'b0;
        best_t = 0;
        best_u = 0;
        best_v = 0;
        best_f = 0;
        if (!vis_q)
            return res;
        for (int f = 0; f < 6; f++)
        begin
            kabs = (k[normal_ax[f]] < 0) ? -k[normal_ax[f]] : k[normal_ax[f]];
            // parallel axis: no candidate on either face
            if (kabs == 0 || kabs < longint'(tol_q))
                continue;
            t = ((o[normal_ax[f]] - plane_of[f] * ONE) * ONE) / (-k[normal_ax[f]]);
            if (t <= 0 || t >= FAR_CLIP)
                continue;
            if (found && t >= best_t)
                continue;
            u = o[u_ax[f]] + scale_fix(t, k[u_ax[f]]);
            v = o[v_ax[f]] + scale_fix(t, k[v_ax[f]]);
            if (u > ONE || u < -ONE || v > ONE || v < -ONE)
                continue;
            found  = 1'b1;
            best_t = t;
            best_u = u;
            best_v = v;
            best_f = f;
        end
        if (!found)
            return res;
        for (int j = 0; j < 3; j++)
            p[j] = clip(o[j] + scale_fix(best_t, k[j]), -64'sh80000000, 64'sh7FFFFFFF);
        res.hit      = 1'b1;
        res.face     = best_f[2:0];
        res.hit_dist = 31'(clip(best_t, 0, 64'sh7FFFFFFF));
        res.u        = 18'(clip(best_u, -131072, 131071));
        res.v        = 18'(clip(best_v, -131072, 131071));
        res.px       = 32'(p[0]);
        res.py       = 32'(p[1]);
        res.pz       = 32'(p[2]);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- driver
    // input side: transfers noted at the rising edge, next ray at the falling
    always @(posedge clk)
    begin
        s_took <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            hit_queue.push_back(trace_cube(s_axis_tdata));
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_wait     <= 0;
        end
        else if (s_axis_tvalid && !s_took)
        begin
            // offer still pending, hold it
        end
        else if (send_wait > 0)
        begin
            send_wait     <= send_wait - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (ray_queue.size() > 0)
        begin
            s_axis_tdata  <= ray_queue.pop_front();
            s_axis_tvalid <= 1'b1;
            send_wait     <= send_gaps ? int'($urandom_range(0, 15)) : 0;
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // --------------------------------------------------------------- monitor
    always @(posedge clk)
    begin
        cube_hit_t want;
        m_took <= m_axis_tvalid && m_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (hit_queue.size() == 0)
                report_mismatch("unexpected transfer", 1, 0);
            else
            begin
                want = hit_queue.pop_front();
                if (m_axis_tuser != want.hit)
                    report_mismatch("hit", m_axis_tuser, want.hit);
                if (m_axis_tdata[2:0] != want.face)
                    report_mismatch("face", m_axis_tdata[2:0], want.face);
                if (m_axis_tdata[33:3] != want.hit_dist)
                    report_mismatch("hit_distance", m_axis_tdata[33:3], want.hit_dist);
                if (m_axis_tdata[51:34] != want.u)
                    report_mismatch("tex_u", $signed(m_axis_tdata[51:34]), want.u);
                if (m_axis_tdata[69:52] != want.v)
                    report_mismatch("tex_v", $signed(m_axis_tdata[69:52]), want.v);
                if (m_axis_tdata[101:70] != want.px)
                    report_mismatch("point_x", $signed(m_axis_tdata[101:70]), want.px);
                if (m_axis_tdata[133:102] != want.py)
                    report_mismatch("point_y", $signed(m_axis_tdata[133:102]), want.py);
                if (m_axis_tdata[165:134] != want.pz)
                    report_mismatch("point_z", $signed(m_axis_tdata[165:134]), want.pz);
            end
        end
    end

    // receiver: per-result stall, plus a long hold-off that lets the pipe fill
    always @(negedge clk or negedge rst_n)
    begin
        int draw;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
        end
        else if (hold_on)
            m_axis_tready <= 1'b0;
        else if (m_took && recv_gaps)
        begin
            draw = int'($urandom_range(0, 15));
            if (draw == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                recv_wait     <= draw - 1;
                m_axis_tready <= 1'b0;
            end
        end
        else if (recv_wait > 0)
        begin
            recv_wait     <= recv_wait - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // register write channel, only used while the block is idle
    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == ruci_pkg::CFG_OBJECT_VISIBLE)
            vis_q = value[0];
        else
            tol_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_pipe();
        while (ray_queue.size() > 0 || s_axis_tvalid || hit_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 16) @(posedge clk);
    endtask

    // rays, most aimed at a point in or just beyond the cube, random spacing
    task automatic queue_random_rays(int count);
        longint kx, ky, kz, tx, ty, tz, s;
        int     pick;
        for (int n = 0; n < count; n++)
        begin
            if (n % 70 == 0)
            begin
                send_gaps = $urandom_range(0, 3) != 0;
                recv_gaps = $urandom_range(0, 3) != 0;
            end
            kx   = int'($urandom_range(0, 131072)) - 65536;
            ky   = int'($urandom_range(0, 131072)) - 65536;
            kz   = int'($urandom_range(0, 131072)) - 65536;
            pick = $urandom_range(0, 9);
            // now and then a component near or at zero
            if ($urandom_range(0, 7) == 0)
                kx = int'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 7) == 0)
                kz = 0;
            if (pick < 6)
            begin
                tx = int'($urandom_range(0, 151552)) - 75776;
                ty = int'($urandom_range(0, 151552)) - 75776;
                tz = int'($urandom_range(0, 151552)) - 75776;
                s  = $urandom_range(0, 5 * 65536);
                ray_queue.push_back(pack_ray(tx - scale_fix(s, kx), ty - scale_fix(s, ky),
                                             tz - scale_fix(s, kz), kx, ky, kz));
            end
            else if (pick < 8)
                ray_queue.push_back(pack_ray(int'($urandom_range(0, 6 * 65536)) - 3 * 65536,
                                             int'($urandom_range(0, 6 * 65536)) - 3 * 65536,
                                             int'($urandom_range(0, 6 * 65536)) - 3 * 65536,
                                             kx, ky, kz));
            else
                ray_queue.push_back(pack_ray(int'($urandom()), int'($urandom()),
                                             int'($urandom()), kx, ky, kz));
        end
    endtask

    // ------------------------------------------------------------- stimulus
    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        vis_q      = 1'b1;
        tol_q      = 16'd1;
        mismatches = 0;
        send_gaps  = 1'b1;
        recv_gaps  = 1'b1;
        hold_on    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one ray straight at each face, from outside
        ray_queue.push_back(pack_ray(0, 0, 3 * ONE, 0, 0, -ONE));
        ray_queue.push_back(pack_ray(0, 0, -3 * ONE, 0, 0, ONE));
        ray_queue.push_back(pack_ray(-3 * ONE, 0, 0, ONE, 0, 0));
        ray_queue.push_back(pack_ray(3 * ONE, 0, 0, -ONE, 0, 0));
        ray_queue.push_back(pack_ray(0, -3 * ONE, 0, 0, ONE, 0));
        ray_queue.push_back(pack_ray(0, 3 * ONE, 0, 0, -ONE, 0));
        // from the center, exit through a face
        ray_queue.push_back(pack_ray(0, 0, 0, ONE, 0, 0));
        // zero direction, and components right at the tolerance
        ray_queue.push_back(pack_ray(0, 0, 0, 0, 0, 0));
        ray_queue.push_back(pack_ray(0, 0, 3 * ONE, 0, 0, -1));
        // grazing a face edge, and corner tie across three faces
        ray_queue.push_back(pack_ray(3 * ONE, ONE, 0, -ONE, 0, 0));
        ray_queue.push_back(pack_ray(3 * ONE, 3 * ONE, 3 * ONE, -37837, -37837, -37837));
        // just missing
        ray_queue.push_back(pack_ray(3 * ONE, ONE + 1, 0, -ONE, 0, 0));
        // origin extremes, huge distances and far clip
        ray_queue.push_back(pack_ray(64'sh7FFFFFFF, 0, 0, -ONE, 0, 0));
        ray_queue.push_back(pack_ray(-64'sh80000000, 0, 0, ONE, 0, 0));
        ray_queue.push_back(pack_ray(64'sh7FFFFFFF, 64'sh7FFFFFFF, -64'sh80000000,
                                     -ONE, -ONE, ONE));
        ray_queue.push_back(pack_ray(5 * ONE, 0, 0, -2, 0, 0));
        ray_queue.push_back(pack_ray(0, 0, 64'sh7FFFFFFF, 0, 0, -1));
        // direction extremes, pointing away, and one ray from inside the cube
        ray_queue.push_back(pack_ray(0, 0, 3 * ONE, ONE, ONE, ONE));
        ray_queue.push_back(pack_ray(ONE / 2, -ONE / 2, 0, -ONE, -ONE, -ONE));
        ray_queue.push_back(pack_ray(2 * ONE, 0, 0, 65535, -1, 1));

        // long hold-off so that the pipe fills and s_axis stalls
        fork
            begin
                hold_on = 1'b1;
                repeat (2000) @(posedge clk);
                hold_on = 1'b0;
            end
        join_none
        queue_random_rays(PER_PHASE);
        drain_pipe();

        write_reg(ruci_pkg::CFG_ZERO_TOLERANCE, 16'd0);
        queue_random_rays(PER_PHASE);
        drain_pipe();

        write_reg(ruci_pkg::CFG_OBJECT_VISIBLE, 16'd0);
        queue_random_rays(PER_PHASE / 2);
        drain_pipe();

        write_reg(ruci_pkg::CFG_OBJECT_VISIBLE, 16'd1);
        write_reg(ruci_pkg::CFG_ZERO_TOLERANCE, 16'hFFFF);
        queue_random_rays(PER_PHASE / 2);
        drain_pipe();

        write_reg(ruci_pkg::CFG_ZERO_TOLERANCE, 16'($urandom_range(2, 40000)));
        queue_random_rays(PER_PHASE);
        drain_pipe();

        write_reg(ruci_pkg::CFG_ZERO_TOLERANCE, 16'd1);
        queue_random_rays(PER_PHASE);
        drain_pipe();

        if (mismatches == 0)
            $display("** ray_unit_cube_intersection: PASSED **");
        else
            $display("** ray_unit_cube_intersection: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("timeout");
        $display("** ray_unit_cube_intersection: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ruci_pkg.sv
rtl/ruci_div_step.sv
rtl/ruci_mulfix.sv
rtl/ruci_select.sv
rtl/ray_unit_cube_intersection.sv
bench/tb.sv
